// ===== hw/rtl/qe_pkg.sv =====
// Types, constants and helper functions shared by the quaternion to Euler converter.
package qe_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_TAB_LEN      = 24;
  localparam int VEC_W   = 34;   // vectors built from the products
  localparam int CW      = 36;   // CORDIC x/y width, room for gain
  localparam int ZW      = 26;   // angle accumulator, degrees * 2^16
  localparam int S_W     = 30;   // clamped sine, Q28
  localparam int RAD_W   = 58;   // radicand, even width
  localparam int ROOT_W  = 29;
  localparam int REM_W   = 31;
  localparam int SQ_STEPS = RAD_W / 2;
  localparam int FRONT_STAGES = 3;
  // front stages, square root steps, pre-rotation and output registers; CORDIC stages not included
  localparam int LAT_BASE = FRONT_STAGES + SQ_STEPS + 2;

  localparam logic signed [ZW-1:0] DEG90 = ZW'(90 * 65536);
  localparam logic signed [15:0] PITCH_LIM = 16'sd11520;
  localparam logic signed [15:0] ANGLE_LIM = 16'sd23040;

  typedef struct packed {
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [15:0] quat_real;
  } quat_in_t;

  typedef struct packed {
    logic signed [14:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [15:0] yaw_angle;
  } euler_out_t;

  // data carried alongside the square root
  typedef struct packed {
    logic signed [S_W-1:0]   s;
    logic signed [VEC_W-1:0] roll_y;
    logic signed [VEC_W-1:0] roll_x;
    logic signed [VEC_W-1:0] yaw_y;
    logic signed [VEC_W-1:0] yaw_x;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } lane_t;

  function automatic logic signed [ZW-1:0] atan_tab(input int n);
    logic signed [ZW-1:0] a;
    case (n)
      0:  a = ZW'(2949120);
      1:  a = ZW'(1740967);
      2:  a = ZW'(919879);
      3:  a = ZW'(466945);
      4:  a = ZW'(234379);
      5:  a = ZW'(117304);
      6:  a = ZW'(58666);
      7:  a = ZW'(29335);
      8:  a = ZW'(14668);
      9:  a = ZW'(7334);
      10: a = ZW'(3667);
      11: a = ZW'(1833);
      12: a = ZW'(917);
      13: a = ZW'(458);
      14: a = ZW'(229);
      15: a = ZW'(115);
      16: a = ZW'(57);
      17: a = ZW'(29);
      18: a = ZW'(14);
      19: a = ZW'(7);
      20: a = ZW'(4);
      21: a = ZW'(2);
      22: a = ZW'(1);
      default: a = '0;
    endcase
    return a;
  endfunction

  // turn a left-half-plane vector into the right half plane
  function automatic lane_t pre_rotate(input logic signed [CW-1:0] y,
                                       input logic signed [CW-1:0] x);
    lane_t l;
    l.zero = (x == '0) && (y == '0);
    l.x = x;
    l.y = y;
    l.z = '0;
    if (x < 0) begin
      if (y >= 0) begin
        l.x = y;
        l.y = -x;
        l.z = DEG90;
      end else begin
        l.x = -y;
        l.y = x;
        l.z = -DEG90;
      end
    end
    return l;
  endfunction

  // degrees * 2^16 to 1/128 degree, round half away from zero, saturate
  function automatic logic signed [15:0] to_units(input lane_t l,
                                                  input logic signed [15:0] lim);
    logic [ZW-1:0] mag;
    logic [ZW-1:0] q;
    logic signed [15:0] r;
    mag = l.z[ZW-1] ? ZW'(-l.z) : ZW'(l.z);
    q = (mag + ZW'(256)) >> 9;
    if (q > ZW'(lim)) q = ZW'(lim);
    r = l.z[ZW-1] ? -16'(q) : 16'(q);
    if (l.zero) r = '0;
    return r;
  endfunction

endpackage

// ===== hw/rtl/qe_front.sv =====
// Product, sum and squaring stages ahead of the square root chain.
module qe_front (
  input  logic                          clk,
  input  qe_pkg::quat_in_t              in_q,
  output qe_pkg::side_t                 side,
  output logic [qe_pkg::RAD_W-1:0]      rad
);
  import qe_pkg::*;

  logic signed [31:0] p_rj_r, p_ki_r, p_ri_r, p_jk_r, p_rk_r, p_ij_r;
  logic signed [31:0] p_ii_r, p_jj_r, p_kk_r;
  side_t side_r, side_nxt, side2_r;
  logic signed [VEC_W-1:0] s_full;
  logic signed [2*S_W-1:0] sq;
  logic [RAD_W-1:0] rad_r;

  always_ff @(posedge clk) begin
    p_rj_r <= in_q.quat_real * in_q.quat_j;
    p_ki_r <= in_q.quat_k * in_q.quat_i;
    p_ri_r <= in_q.quat_real * in_q.quat_i;
    p_jk_r <= in_q.quat_j * in_q.quat_k;
    p_rk_r <= in_q.quat_real * in_q.quat_k;
    p_ij_r <= in_q.quat_i * in_q.quat_j;
    p_ii_r <= in_q.quat_i * in_q.quat_i;
    p_jj_r <= in_q.quat_j * in_q.quat_j;
    p_kk_r <= in_q.quat_k * in_q.quat_k;
  end

  always_comb begin
    s_full = (VEC_W'(p_rj_r) - VEC_W'(p_ki_r)) <<< 1;
    side_nxt.roll_y = (VEC_W'(p_ri_r) + VEC_W'(p_jk_r)) <<< 1;
    side_nxt.roll_x = VEC_W'(1 <<< 28) - ((VEC_W'(p_ii_r) + VEC_W'(p_jj_r)) <<< 1);
    side_nxt.yaw_y  = (VEC_W'(p_rk_r) + VEC_W'(p_ij_r)) <<< 1;
    side_nxt.yaw_x  = VEC_W'(1 <<< 28) - ((VEC_W'(p_jj_r) + VEC_W'(p_kk_r)) <<< 1);
    // clamp the sine to plus or minus one
    if (s_full > VEC_W'(1 <<< 28)) begin
      side_nxt.s = S_W'(1 <<< 28);
    end else if (s_full < -VEC_W'(1 <<< 28)) begin
      side_nxt.s = -S_W'(1 <<< 28);
    end else begin
      side_nxt.s = s_full[S_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    side_r <= side_nxt;
  end

  assign sq = side_r.s * side_r.s;

  always_ff @(posedge clk) begin
    side2_r <= side_r;
    rad_r   <= (RAD_W'(1) << 56) - sq[RAD_W-1:0];
  end

  assign side = side2_r;
  assign rad  = rad_r;

endmodule

// ===== hw/rtl/qe_sqrt_cell.sv =====
// One digit step of the integer square root, with side data passed along.
module qe_sqrt_cell (
  input  logic                        clk,
  input  logic [qe_pkg::RAD_W-1:0]    rad_in,
  input  logic [qe_pkg::REM_W-1:0]    rem_in,
  input  logic [qe_pkg::ROOT_W-1:0]   root_in,
  input  qe_pkg::side_t               side_in,
  output logic [qe_pkg::RAD_W-1:0]    rad_out,
  output logic [qe_pkg::REM_W-1:0]    rem_out,
  output logic [qe_pkg::ROOT_W-1:0]   root_out,
  output qe_pkg::side_t               side_out
);
  import qe_pkg::*;

  logic [REM_W+1:0] rem_sh, trial;
  logic [REM_W-1:0] rem_nxt;
  logic [ROOT_W-1:0] root_nxt;
  logic [RAD_W-1:0] rad_r;
  logic [REM_W-1:0] rem_r;
  logic [ROOT_W-1:0] root_r;
  side_t side_r;

  always_comb begin
    rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
    trial  = (REM_W+2)'({root_in, 2'b01});
    if (rem_sh >= trial) begin
      rem_nxt  = REM_W'(rem_sh - trial);
      root_nxt = {root_in[ROOT_W-2:0], 1'b1};
    end else begin
      rem_nxt  = rem_sh[REM_W-1:0];
      root_nxt = {root_in[ROOT_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= {rad_in[RAD_W-3:0], 2'b00};
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
    side_r <= side_in;
  end

  assign rad_out  = rad_r;
  assign rem_out  = rem_r;
  assign root_out = root_r;
  assign side_out = side_r;

endmodule

// ===== hw/rtl/qe_cordic_cell.sv =====
// One vectoring CORDIC stage for a single lane.
module qe_cordic_cell #(
  parameter int STAGE = 0
) (
  input  logic          clk,
  input  qe_pkg::lane_t lane_in,
  output qe_pkg::lane_t lane_out
);
  import qe_pkg::*;

  lane_t lane_r, lane_nxt;
  logic signed [CW-1:0] dx, dy;

  always_comb begin
    dx = lane_in.y >>> STAGE;
    dy = lane_in.x >>> STAGE;
    lane_nxt.zero = lane_in.zero;
    if (lane_in.y > 0) begin
      lane_nxt.x = lane_in.x + dx;
      lane_nxt.y = lane_in.y - dy;
      lane_nxt.z = lane_in.z + atan_tab(STAGE);
    end else begin
      lane_nxt.x = lane_in.x - dx;
      lane_nxt.y = lane_in.y + dy;
      lane_nxt.z = lane_in.z - atan_tab(STAGE);
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
  end

  assign lane_out = lane_r;

endmodule

// ===== hw/rtl/quaternion_to_euler_angles.sv =====
// Top level: pipelined quaternion to pitch, roll and yaw converter.
//
//  channel | handshake        | payload
//  --------+------------------+---------------------------
//  input   | start / busy     | in_data  (qe_pkg::quat_in_t)
//  result  | out_valid strobe | out_data (qe_pkg::euler_out_t)
//
// One transaction per cycle; busy stays low. Each result passes through the
// front stages, the 29-cell square root chain, the pre-rotation register, the
// CORDIC cell chain (stages capped at 24) and the output register.
// Synchronous reset clears the valid line only; the result strobe is a
// one-cycle pulse and the receiver cannot stall it.
module quaternion_to_euler_angles #(
  parameter int CORDIC_STAGES = qe_pkg::CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  qe_pkg::quat_in_t   in_data,
  output logic               out_valid,
  output qe_pkg::euler_out_t out_data
);
  import qe_pkg::*;

  localparam int STAGES = (CORDIC_STAGES > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STAGES;
  localparam int VLEN   = LAT_BASE - 1 + STAGES;

  logic [VLEN-1:0] valid_r, valid_nxt;
  logic out_valid_r;
  euler_out_t out_data_r;

  logic [RAD_W-1:0]  rad_c  [SQ_STEPS+1];
  logic [REM_W-1:0]  rem_c  [SQ_STEPS+1];
  logic [ROOT_W-1:0] root_c [SQ_STEPS+1];
  side_t             side_c [SQ_STEPS+1];

  lane_t pitch_c [STAGES+1];
  lane_t roll_c  [STAGES+1];
  lane_t yaw_c   [STAGES+1];
  side_t side_last;

  assign busy = 1'b0;

  // advance the valid line one stage per cycle
  assign valid_nxt = {valid_r[VLEN-2:0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      valid_r     <= valid_nxt;
      out_valid_r <= valid_r[VLEN-1];
    end
  end

  qe_front u_front (
    .clk  (clk),
    .in_q (in_data),
    .side (side_c[0]),
    .rad  (rad_c[0])
  );

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    qe_sqrt_cell u_cell (
      .clk      (clk),
      .rad_in   (rad_c[g]),
      .rem_in   (rem_c[g]),
      .root_in  (root_c[g]),
      .side_in  (side_c[g]),
      .rad_out  (rad_c[g+1]),
      .rem_out  (rem_c[g+1]),
      .root_out (root_c[g+1]),
      .side_out (side_c[g+1])
    );
  end

  assign side_last = side_c[SQ_STEPS];

  always_ff @(posedge clk) begin
    pitch_c[0] <= pre_rotate(CW'(side_last.s), CW'(root_c[SQ_STEPS]));
    roll_c[0]  <= pre_rotate(CW'(side_last.roll_y), CW'(side_last.roll_x));
    yaw_c[0]   <= pre_rotate(CW'(side_last.yaw_y), CW'(side_last.yaw_x));
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_cordic
    qe_cordic_cell #(.STAGE(g)) u_pitch (
      .clk (clk), .lane_in (pitch_c[g]), .lane_out (pitch_c[g+1])
    );
    qe_cordic_cell #(.STAGE(g)) u_roll (
      .clk (clk), .lane_in (roll_c[g]), .lane_out (roll_c[g+1])
    );
    qe_cordic_cell #(.STAGE(g)) u_yaw (
      .clk (clk), .lane_in (yaw_c[g]), .lane_out (yaw_c[g+1])
    );
  end

  always_ff @(posedge clk) begin
    out_data_r.pitch_angle <= 15'(to_units(pitch_c[STAGES], PITCH_LIM));
    out_data_r.roll_angle  <= to_units(roll_c[STAGES], ANGLE_LIM);
    out_data_r.yaw_angle   <= to_units(yaw_c[STAGES], ANGLE_LIM);
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== hw/rtl/qe_checker.sv =====
// Port-level checks for the converter, bound to the top level.
module qe_checker #(
  parameter int CORDIC_STAGES = qe_pkg::CORDIC_STAGES_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input qe_pkg::euler_out_t out_data,
  input logic               out_valid
);
  import qe_pkg::*;

  localparam int STAGES = (CORDIC_STAGES > ATAN_TAB_LEN) ? ATAN_TAB_LEN : CORDIC_STAGES;
  localparam int LAT    = LAT_BASE + STAGES;

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("transaction produced no result");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("result without a transaction");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.pitch_angle >= -15'sd11520 && out_data.pitch_angle <= 15'sd11520
                   && out_data.roll_angle >= -16'sd23040
                   && out_data.roll_angle <= 16'sd23040
                   && out_data.yaw_angle >= -16'sd23040
                   && out_data.yaw_angle <= 16'sd23040))
    else $error("angle out of range");

endmodule

bind quaternion_to_euler_angles qe_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_qe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);

// ===== verif/quaternion_to_euler_angles_tb.sv =====
// Self-checking testbench for the quaternion to Euler angle converter.
`timescale 1ns / 1ps

module quaternion_to_euler_angles_tb;
  import qe_pkg::*;

  localparam int STAGES      = 16;
  localparam int LATENCY     = 34 + STAGES;
  localparam int N_RANDOM    = 750;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_DIRECTED  = 18;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  quat_in_t   in_data;
  logic       out_valid;
  euler_out_t out_data;

  euler_out_t angle_queue[$];
  int         error_count;
  int         result_count;
  int         cycle_count;
  int         directed_count;

  typedef struct {
    quat_in_t   q;
    logic       known;
    euler_out_t angles;
  } quat_row_t;

  quat_row_t quat_rows[N_DIRECTED];

  quaternion_to_euler_angles #(.CORDIC_STAGES(STAGES)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // floor shift right of a signed value
  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint root_floor(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint z;
    longint t;
    longint dx;
    longint dy;
    longint tab[24];
    int     n;
    tab = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 90 * 65536;
      end else begin
        x = -y;
        y = t;
        z = -90 * 65536;
      end
    end
    for (n = 0; n < ((STAGES > 24) ? 24 : STAGES); n++) begin
      dx = floor_shift(y, n);
      dy = floor_shift(x, n);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += tab[n];
      end else begin
        x -= dx;
        y += dy;
        z -= tab[n];
      end
    end
    return z;
  endfunction

  function automatic longint degree_units(longint z, longint lim);
    longint q;
    q = (z >= 0) ? (z + 256) / 512 : -((-z + 256) / 512);
    if (q > lim) q = lim;
    if (q < -lim) q = -lim;
    return q;
  endfunction

  function automatic euler_out_t predict_angles(quat_in_t q);
    longint     qi;
    longint     qj;
    longint     qk;
    longint     qr;
    longint     s;
    longint     c;
    longint     one;
    euler_out_t e;
    qi = q.quat_i;
    qj = q.quat_j;
    qk = q.quat_k;
    qr = q.quat_real;
    one = 64'sd1 <<< 28;
    s = 2 * (qr * qj - qk * qi);
    if (s > one) s = one;
    if (s < -one) s = -one;
    c = root_floor(one * one - s * s);
    e.pitch_angle = 15'(degree_units(vector_angle(s, c), 11520));
    e.roll_angle = 16'(degree_units(vector_angle(2 * (qr * qi + qj * qk),
                                                 one - 2 * (qi * qi + qj * qj)), 23040));
    e.yaw_angle = 16'(degree_units(vector_angle(2 * (qr * qk + qi * qj),
                                                one - 2 * (qj * qj + qk * qk)), 23040));
    return e;
  endfunction

  function automatic quat_row_t make_row(int i, int j, int k, int r, logic known,
                                         int p, int ro, int y);
    quat_row_t w;
    w.q = '{quat_i: 16'(i), quat_j: 16'(j), quat_k: 16'(k), quat_real: 16'(r)};
    w.known = known;
    w.angles = '{pitch_angle: 15'(p), roll_angle: 16'(ro), yaw_angle: 16'(y)};
    return w;
  endfunction

  // identity, zero vector, extremes, gimbal poles, clamped sine, saturation
  initial begin
    quat_rows[0]  = make_row(0, 0, 0, 16384, 1, 0, 0, 0);
    quat_rows[1]  = make_row(0, 0, 0, 0, 1, 0, 0, 0);
    quat_rows[2]  = make_row(0, 11585, 0, 11585, 0, 0, 0, 0);
    quat_rows[3]  = make_row(0, -11585, 0, 11585, 0, 0, 0, 0);
    // oversized components: sine clamps, roll and yaw land on +180
    quat_rows[4]  = make_row(0, 32767, 0, 32767, 1, 11520, 23040, 23040);
    quat_rows[5]  = make_row(0, -32768, 0, 32767, 1, -11520, 23040, 23040);
    quat_rows[6]  = make_row(16384, 0, 0, 0, 0, 0, 0, 0);
    quat_rows[7]  = make_row(0, 0, 16384, 0, 0, 0, 0, 0);
    quat_rows[8]  = make_row(11585, 0, 0, 11585, 0, 0, 0, 0);
    quat_rows[9]  = make_row(0, 0, -11585, 11585, 0, 0, 0, 0);
    quat_rows[10] = make_row(32767, 32767, 32767, 32767, 0, 0, 0, 0);
    quat_rows[11] = make_row(-32768, -32768, -32768, -32768, 0, 0, 0, 0);
    quat_rows[12] = make_row(-32768, 32767, -32768, 32767, 0, 0, 0, 0);
    quat_rows[13] = make_row(16384, 0, 1, 0, 0, 0, 0, 0);
    quat_rows[14] = make_row(16384, 0, -1, 0, 0, 0, 0, 0);
    quat_rows[15] = make_row(1, 0, 0, 0, 0, 0, 0, 0);
    quat_rows[16] = make_row(0, 16384, 16384, 0, 0, 0, 0, 0);
    quat_rows[17] = make_row(-1, -1, -1, -1, 0, 0, 0, 0);
  end

  task automatic send_quat(quat_in_t q, logic known, euler_out_t angles, logic idle_ok);
    while (idle_ok && $urandom_range(99) < 35) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= q;
    angle_queue.push_back(known ? angles : predict_angles(q));
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic quat_in_t random_quat(int mode);
    quat_in_t q;
    real      a;
    real      b;
    real      c;
    real      d;
    real      n;
    if (mode == 0) begin
      q = {$urandom, $urandom};
    end else begin
      // near-unit quaternion with random direction
      a = $urandom_range(65535) - 32768.0;
      b = $urandom_range(65535) - 32768.0;
      c = $urandom_range(65535) - 32768.0;
      d = $urandom_range(65535) - 32768.0;
      n = $sqrt(a * a + b * b + c * c + d * d) + 1.0;
      q.quat_i = 16'($rtoi(a * 16384.0 / n));
      q.quat_j = 16'($rtoi(b * 16384.0 / n));
      q.quat_k = 16'($rtoi(c * 16384.0 / n));
      q.quat_real = 16'($rtoi(d * 16384.0 / n));
    end
    return q;
  endfunction

  always @(posedge clk) begin
    euler_out_t want;
    if (rst_n && out_valid) begin
      if (angle_queue.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        error_count++;
      end else begin
        want = angle_queue.pop_front();
        result_count++;
        if (out_data.pitch_angle !== want.pitch_angle)
          $display("%0t: pitch expected %0d actual %0d", $time, want.pitch_angle,
                   out_data.pitch_angle);
        if (out_data.roll_angle !== want.roll_angle)
          $display("%0t: roll expected %0d actual %0d", $time, want.roll_angle,
                   out_data.roll_angle);
        if (out_data.yaw_angle !== want.yaw_angle)
          $display("%0t: yaw expected %0d actual %0d", $time, want.yaw_angle,
                   out_data.yaw_angle);
        if (out_data !== want) error_count++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("quaternion_to_euler_angles: mismatch");
      $finish;
    end
  end

  initial begin
    int idx;
    error_count = 0;
    result_count = 0;
    cycle_count = 0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (idx = 0; idx < N_DIRECTED; idx++)
      send_quat(quat_rows[idx].q, quat_rows[idx].known, quat_rows[idx].angles, 1'b1);
    directed_count = N_DIRECTED;

    for (idx = 0; idx < N_RANDOM; idx++) begin
      // hold off until the pipeline drains once
      if (idx == N_RANDOM / 2) begin
        start <= 1'b0;
        @(posedge clk);
        while (angle_queue.size() != 0) @(posedge clk);
      end
      send_quat(random_quat($urandom_range(99) < 70), 1'b0, '0,
                !(idx >= 200 && idx < 300));
    end
    start <= 1'b0;

    while (angle_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("covered %0d directed and %0d random quaternions, %0d results checked",
             directed_count, N_RANDOM, result_count);
    if (error_count == 0)
      $display("quaternion_to_euler_angles: match");
    else
      $display("quaternion_to_euler_angles: mismatch");
    $finish;
  end

endmodule
